FILE: hw/rtl/ust_pkg.sv
package ust_pkg;

  // Payload widths, fixed by the item format.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SIZE_W   = 7;

  // Request codes. The unused code is served as a lookup.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_DUP     = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_COMMIT = 2'd2
  } state_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear_hit;
    logic scan;
    logic wr_insert;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/ust_in_if.sv
interface ust_in_if;
  import ust_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

FILE: hw/rtl/ust_out_if.sv
interface ust_out_if;
  import ust_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [SIZE_W-1:0]   size;

  modport source (output valid, output found, output status, output size, input ready);
  modport sink (input valid, input found, input status, input size, output ready);
endinterface

FILE: hw/rtl/ust_cell.sv
module ust_cell #(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned INDEX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ust_pkg::cell_ctl_t         ctl_i,
  input  logic [ust_pkg::VALUE_W-1:0] key_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic                       prev_hit_i,
  input  logic [ust_pkg::VALUE_W-1:0] next_entry_i,
  output logic                       hit_o,
  output logic [ust_pkg::VALUE_W-1:0] entry_o
);
  import ust_pkg::*;

  logic [VALUE_W-1:0] entry_q, entry_d;
  logic               hit_q, hit_d;
  logic               occupied;
  logic               match;

  // This cell holds a live element when its position is below the count.
  assign occupied = CNT_W'(INDEX) < count_i;
  assign match    = occupied && (entry_q == key_i);

  // The hit flag ripples down the row one cell per cycle; once settled it
  // tells whether the key sits in this cell or any cell before it.
  always_comb begin
    hit_d = hit_q;
    if (ctl_i.clear_hit) begin
      hit_d = 1'b0;
    end else if (ctl_i.scan) begin
      hit_d = prev_hit_i | match;
    end
  end

  // An insert fills the first free cell; a remove closes the gap by taking
  // the neighbor's element in every cell from the match onward.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.wr_insert && (CNT_W'(INDEX) == count_i)) begin
      entry_d = key_i;
    end else if (ctl_i.shift && hit_q) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign hit_o   = hit_q;
  assign entry_o = entry_q;

endmodule

FILE: hw/rtl/unordered_set_table.sv
// Unordered set of up to CAPACITY 32-bit values held in a row of cells.
// The result is registered: the request is latched, the match flag ripples through
// the row one cell per cycle in the scan state, and the commit state writes the
// result. Only one request is in flight at a time; the next request is taken
// while a finished result still waits in the output register, and its commit
// stalls until that result has been taken.
// Reset clears the element count and control state; cell contents are not reset.
module unordered_set_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ust_in_if.sink     in_i,
  ust_out_if.source  out_o
);
  import ust_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SCAN_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_e              state_q, state_d;
  logic [SCAN_W-1:0]   scan_cnt_q, scan_cnt_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ACTION_W-1:0] action_q;
  logic [VALUE_W-1:0]  key_q;
  cell_ctl_t           ctl;
  logic                accept;
  logic                commit;
  logic                found;

  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_found_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SIZE_W-1:0]   out_size_q, out_size_d;
  status_e             status;

  logic               hits [CAPACITY];
  logic [VALUE_W-1:0] ents [CAPACITY];

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign found      = hits[CAPACITY-1];

  // Row of cells; each passes its hit flag down and its element up.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               prev_hit;
    logic [VALUE_W-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_hit = 1'b0;
    end else begin : g_mid
      assign prev_hit = hits[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = ents[i+1];
    end

    ust_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_q),
      .count_i      (count_q),
      .prev_hit_i   (prev_hit),
      .next_entry_i (next_entry),
      .hit_o        (hits[i]),
      .entry_o      (ents[i])
    );
  end

  // Sequencer: take a request, let the hit flag run the row, then commit.
  always_comb begin
    state_d      = state_q;
    scan_cnt_d   = scan_cnt_q;
    count_d      = count_q;
    ctl          = '0;
    commit       = 1'b0;
    status       = STAT_OK;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_size_d   = out_size_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl.clear_hit = 1'b1;
          scan_cnt_d    = '0;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan   = 1'b1;
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == SCAN_W'(CAPACITY - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!out_valid_q || out_o.ready) begin
          commit = 1'b1;
          case (action_q)
            ACT_INSERT: begin
              if (found) begin
                status = STAT_DUP;
              end else if (count_q == CNT_W'(CAPACITY)) begin
                status = STAT_FULL;
              end else begin
                ctl.wr_insert = 1'b1;
                count_d       = count_q + 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (found) begin
                ctl.shift = 1'b1;
                count_d   = count_q - 1'b1;
              end else begin
                status = STAT_MISSING;
              end
            end
            default: begin
              status = STAT_OK;
            end
          endcase
          out_valid_d  = 1'b1;
          out_found_d  = found;
          out_status_d = status;
          out_size_d   = SIZE_W'(count_d);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_i.action;
      key_q    <= in_i.value;
    end
    if (commit) begin
      out_found_q  <= out_found_d;
      out_status_q <= out_status_d;
      out_size_q   <= out_size_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.found  = out_found_q;
  assign out_o.status = out_status_q;
  assign out_o.size   = out_size_q;

endmodule
